// ===== sv/range_progression_add_engine_macros.svh =====
// assertion macros shared by the checker
`ifndef RANGE_PROGRESSION_ADD_ENGINE_MACROS_SVH
`define RANGE_PROGRESSION_ADD_ENGINE_MACROS_SVH

// condition implies a consequence on the next edge
`define RPAE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// condition implies a consequence on the same edge
`define RPAE_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== sv/rpae_pkg.sv =====
package rpae_pkg;

  localparam int MAX_LENGTH_DEF = 1024;
  localparam int LEN_RESET      = 1024;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LO,
    ST_UPD_E,
    ST_UPD_E1,
    ST_RD_SUM1,
    ST_RD_SUM2,
    ST_RD_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_UPD_LO,
    OP_UPD_E,
    OP_UPD_E1,
    OP_RD_SUM1,
    OP_RD_SUM2,
    OP_RD_EMIT
  } op_t;

  typedef struct packed {
    logic accept;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic upd_go;
    logic rd_go;
    logic clr_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== sv/rpae_intf.sv =====
interface rpae_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [9:0]         load_index;
  logic signed [31:0] load_value;
  logic [10:0]        range_start;
  logic [10:0]        range_end;
  logic signed [31:0] step;

  modport source (output valid, req_type, load_index, load_value, range_start, range_end,
                  step, input ready);
  modport sink (input valid, req_type, load_index, load_value, range_start, range_end,
                step, output ready);
endinterface

interface rpae_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] element_value;
  logic [9:0]         element_index;
  logic               last;

  modport source (output valid, element_value, element_index, last, input ready);
  modport sink (input valid, element_value, element_index, last, output ready);
endinterface

interface rpae_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] array_length;

  modport source (output valid, array_length, input ready);
  modport sink (input valid, array_length, output ready);
endinterface

// ===== sv/rpae_ctrl.sv =====
module rpae_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rpae_pkg::sts_t sts,
  output rpae_pkg::cmd_t cmd
);

  rpae_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpae_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpae_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = rpae_pkg::ST_IDLE;
      end
      rpae_pkg::ST_IDLE: begin
        if (in_valid && sts.upd_go) state_nxt = rpae_pkg::ST_UPD_LO;
        else if (in_valid && sts.rd_go) state_nxt = rpae_pkg::ST_RD_SUM1;
      end
      rpae_pkg::ST_UPD_LO:  state_nxt = rpae_pkg::ST_UPD_E;
      rpae_pkg::ST_UPD_E:   state_nxt = rpae_pkg::ST_UPD_E1;
      rpae_pkg::ST_UPD_E1:  state_nxt = rpae_pkg::ST_IDLE;
      rpae_pkg::ST_RD_SUM1: state_nxt = rpae_pkg::ST_RD_SUM2;
      rpae_pkg::ST_RD_SUM2: state_nxt = rpae_pkg::ST_RD_EMIT;
      rpae_pkg::ST_RD_EMIT: begin
        if (!sts.out_busy) state_nxt = rpae_pkg::ST_IDLE;
      end
      default: state_nxt = rpae_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == rpae_pkg::ST_IDLE);
    cmd.accept = in_ready && in_valid;
    cmd.op     = rpae_pkg::OP_NONE;
    unique case (state_r)
      rpae_pkg::ST_CLEAR:   cmd.op = rpae_pkg::OP_CLEAR;
      rpae_pkg::ST_IDLE:    cmd.op = rpae_pkg::OP_NONE;
      rpae_pkg::ST_UPD_LO:  cmd.op = rpae_pkg::OP_UPD_LO;
      rpae_pkg::ST_UPD_E:   cmd.op = rpae_pkg::OP_UPD_E;
      rpae_pkg::ST_UPD_E1:  cmd.op = rpae_pkg::OP_UPD_E1;
      rpae_pkg::ST_RD_SUM1: cmd.op = rpae_pkg::OP_RD_SUM1;
      rpae_pkg::ST_RD_SUM2: cmd.op = rpae_pkg::OP_RD_SUM2;
      rpae_pkg::ST_RD_EMIT: begin
        cmd.op = sts.out_busy ? rpae_pkg::OP_NONE : rpae_pkg::OP_RD_EMIT;
      end
      default: cmd.op = rpae_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== sv/rpae_dp.sv =====
module rpae_dp #(
  parameter int MAX_LENGTH = rpae_pkg::MAX_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpae_pkg::cmd_t     cmd,
  output rpae_pkg::sts_t     sts,
  input  logic [1:0]         req_type,
  input  logic [9:0]         load_index,
  input  logic signed [31:0] load_value,
  input  logic [10:0]        range_start,
  input  logic [10:0]        range_end,
  input  logic signed [31:0] step,
  input  logic               cfg_valid,
  input  logic [10:0]        cfg_array_length,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [63:0] element_value,
  output logic [9:0]         element_index,
  output logic               last
);

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = (AW > 11) ? AW + 1 : 12;
  localparam int LenCap = (MAX_LENGTH > 2047) ? 2047 : MAX_LENGTH;
  localparam logic [10:0] LEN_CAP  = 11'(LenCap);
  localparam logic [10:0] LEN_INIT =
    (rpae_pkg::LEN_RESET > LenCap) ? LEN_CAP : 11'(rpae_pkg::LEN_RESET);
  localparam logic [AW-1:0] CLR_END = AW'(MAX_LENGTH - 1);

  logic [31:0] base_mem [MAX_LENGTH];
  logic [63:0] diff_mem [MAX_LENGTH];
  logic [31:0] base_q;
  logic [63:0] diff_q;

  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0]   wr_data;
  logic          wr_en;

  logic [10:0]   len_r, len_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [63:0]   f_r, f_nxt, s_r, s_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [AW-1:0] lo_r;
  logic [10:0]   e_r;
  logic          e_ok_r, e1_ok_r;
  logic [63:0]   d_r, prod1_r, prod2_r;
  logic [63:0]   value_r;
  logic [9:0]    index_r;
  logic          last_r;

  logic [10:0]        lo_w, span_w;
  logic signed [43:0] prod_w;
  logic               upd_ok, load_ok, rp_last;

  always_comb begin
    lo_w    = range_start - 11'd1;
    span_w  = range_end - lo_w;
    prod_w  = $signed({1'b0, span_w}) * step;
    upd_ok  = (range_start != 11'd0) && (range_start <= range_end) && (range_end <= len_r);
    load_ok = (32'(load_index) < MAX_LENGTH);
    rp_last = (CW'(rp_r) + CW'(1)) >= CW'(len_r);

    sts.upd_go   = (req_type == rpae_pkg::REQ_UPDATE) && upd_ok;
    sts.rd_go    = (req_type == rpae_pkg::REQ_READ);
    sts.clr_last = (clr_r == CLR_END);
    sts.out_busy = out_valid_r && !out_ready;
  end

  // effective length is stored at write time
  always_comb begin
    len_nxt = len_r;
    if (cfg_valid) begin
      if (cfg_array_length == 11'd0) len_nxt = 11'd1;
      else if (cfg_array_length > LEN_CAP) len_nxt = LEN_CAP;
      else len_nxt = cfg_array_length;
    end
  end

  always_comb begin
    unique case (cmd.op)
      rpae_pkg::OP_UPD_LO: rd_addr = AW'(e_r);
      rpae_pkg::OP_UPD_E:  rd_addr = AW'(e_r + 11'd1);
      default: begin
        rd_addr = (req_type == rpae_pkg::REQ_UPDATE) ? AW'(lo_w) : rp_r;
      end
    endcase
  end

  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = rp_r;
    wr_data       = 64'd0;
    clr_nxt       = clr_r;
    rp_nxt        = rp_r;
    f_nxt         = f_r;
    s_nxt         = s_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (cmd.op)
      rpae_pkg::OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
      end
      rpae_pkg::OP_UPD_LO: begin
        wr_en   = 1'b1;
        wr_addr = lo_r;
        wr_data = diff_q + d_r;
      end
      rpae_pkg::OP_UPD_E: begin
        wr_en   = e_ok_r;
        wr_addr = AW'(e_r);
        wr_data = diff_q - prod1_r;
      end
      rpae_pkg::OP_UPD_E1: begin
        wr_en   = e1_ok_r;
        wr_addr = AW'(e_r + 11'd1);
        wr_data = diff_q + prod2_r;
      end
      rpae_pkg::OP_RD_SUM1: begin
        // consume and zero the entry
        wr_en = 1'b1;
        f_nxt = f_r + diff_q;
      end
      rpae_pkg::OP_RD_SUM2: begin
        s_nxt = s_r + f_r;
      end
      rpae_pkg::OP_RD_EMIT: begin
        out_valid_nxt = 1'b1;
        if (rp_last) begin
          rp_nxt = '0;
          f_nxt  = 64'd0;
          s_nxt  = 64'd0;
        end else begin
          rp_nxt = rp_r + AW'(1);
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_INIT;
      clr_r       <= '0;
      rp_r        <= '0;
      f_r         <= 64'd0;
      s_r         <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      clr_r       <= clr_nxt;
      rp_r        <= rp_nxt;
      f_r         <= f_nxt;
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lo_r    <= AW'(lo_w);
      e_r     <= range_end;
      d_r     <= 64'(step);
      prod2_r <= 64'(prod_w);
      e_ok_r  <= (range_end < len_r);
      e1_ok_r <= ((12'(range_end) + 12'd1) < 12'(len_r));
    end
    if (cmd.op == rpae_pkg::OP_UPD_LO) begin
      prod1_r <= prod2_r + d_r;
    end
    if (cmd.op == rpae_pkg::OP_RD_EMIT) begin
      value_r <= 64'($signed(base_q)) + s_r;
      index_r <= 10'(rp_r);
      last_r  <= rp_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      diff_mem[wr_addr] <= wr_data;
    end
    diff_q <= diff_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (req_type == rpae_pkg::REQ_LOAD) && load_ok) begin
      base_mem[AW'(load_index)] <= load_value;
    end
    base_q <= base_mem[rp_r];
  end

  assign out_valid     = out_valid_r;
  assign element_value = value_r;
  assign element_index = index_r;
  assign last          = last_r;

endmodule

// ===== sv/range_progression_add_engine.sv =====
// load: taken from idle, no result, next request accepted the following cycle
// update: three read-modify-writes through the one difference memory port
// read: steps through RD_SUM1, RD_SUM2 and RD_EMIT, which loads the result register;
//   no request is taken meanwhile; RD_EMIT waits while a stalled sink holds the output
// reset: synchronous, active low; then a clearing pass over every entry of the
//   difference memory with in_ready low; configuration writes are taken throughout
module range_progression_add_engine #(
  parameter int MAX_LENGTH = rpae_pkg::MAX_LENGTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  rpae_in_if.sink     in_req,
  rpae_out_if.source  out_res,
  rpae_cfg_if.sink    cfg_wr
);

  rpae_pkg::cmd_t cmd;
  rpae_pkg::sts_t sts;

  assign cfg_wr.ready = 1'b1;

  rpae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpae_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .req_type         (in_req.req_type),
    .load_index       (in_req.load_index),
    .load_value       (in_req.load_value),
    .range_start      (in_req.range_start),
    .range_end        (in_req.range_end),
    .step             (in_req.step),
    .cfg_valid        (cfg_wr.valid),
    .cfg_array_length (cfg_wr.array_length),
    .out_ready        (out_res.ready),
    .out_valid        (out_res.valid),
    .element_value    (out_res.element_value),
    .element_index    (out_res.element_index),
    .last             (out_res.last)
  );

endmodule

// ===== sv/rpae_chk.sv =====
`include "range_progression_add_engine_macros.svh"

module rpae_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_req_type,
  input logic       out_valid,
  input logic       out_ready
);

  logic out_stall, load_take, read_take;

  assign out_stall = out_valid && !out_ready;
  assign load_take = in_valid && in_ready && (in_req_type == rpae_pkg::REQ_LOAD);
  assign read_take = in_valid && in_ready && (in_req_type == rpae_pkg::REQ_READ);

  `RPAE_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "result dropped while stalled")
  `RPAE_ASSERT_SAME(a_emit_busy, $rose(out_valid), $past(!in_ready), "result without busy phase")
  `RPAE_ASSERT_NEXT(a_load_quick, load_take, in_ready, "load held the block")
  `RPAE_ASSERT_NEXT(a_read_busy, read_take, !in_ready, "read did not occupy the block")

endmodule

bind range_progression_add_engine rpae_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .in_req_type (in_req.req_type),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready)
);

// ===== tb/range_progression_add_engine_tb.sv =====
`timescale 1ns / 1ps

module range_progression_add_engine_tb;

  localparam int DEPTH = rpae_pkg::MAX_LENGTH_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_CYCLES = 600;
  localparam int STALL_AFTER = 300;
  localparam int PHASES = 13;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int ROWS = 24;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]  req;
    logic [9:0]  index;
    logic [31:0] value;
    logic [10:0] rs;
    logic [10:0] re;
    logic [31:0] step;
  } request_t;

  typedef struct packed {
    logic [63:0] value;
    logic [9:0]  index;
    logic        last;
  } element_t;

  typedef struct packed {
    bit          is_cfg;
    logic [10:0] length;
    request_t    rq;
    bit          known;
    element_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  rpae_in_if  in_ch ();
  rpae_out_if out_ch ();
  rpae_cfg_if cfg_ch ();

  range_progression_add_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch),
    .out_res(out_ch),
    .cfg_wr (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model of the engine
  logic [31:0] base_mem [0:DEPTH-1];
  logic [63:0] diff_mem [0:DEPTH-1];
  bit          written [0:DEPTH-1];
  int unsigned rd_ptr;
  logic [63:0] run_sum1;
  logic [63:0] run_sum2;
  logic [10:0] cfg_len;

  element_t pending_elements [$];
  int       mismatch_count = 0;
  int       results_seen = 0;
  int       counted = 0;
  bit       sender_steady = 1'b0;
  bit       sink_steady = 1'b0;

  function automatic int unsigned active_length();
    if (cfg_len == 11'd0) return 1;
    if (cfg_len > DEPTH) return DEPTH;
    return 32'(cfg_len);
  endfunction

  function automatic void advance_engine(input request_t rq, output element_t res,
                                         output bit got);
    int unsigned len, s, e, lo, p;
    logic [63:0] d, span;
    got = 1'b0;
    res = '0;
    len = active_length();
    case (rq.req)
      rpae_pkg::REQ_LOAD: base_mem[rq.index] = rq.value;
      rpae_pkg::REQ_UPDATE: begin
        s = 32'(rq.rs);
        e = 32'(rq.re);
        d = {{32{rq.step[31]}}, rq.step};
        if (s != 0 && s <= e && e <= len) begin
          lo = s - 1;
          span = 64'(e - lo);
          diff_mem[lo] = diff_mem[lo] + d;
          if (e < len) diff_mem[e] = diff_mem[e] - (span + 64'd1) * d;
          if (e + 1 < len) diff_mem[e + 1] = diff_mem[e + 1] + span * d;
        end
      end
      rpae_pkg::REQ_READ: begin
        p = (rd_ptr >= DEPTH) ? 0 : rd_ptr;
        run_sum1 = run_sum1 + diff_mem[p];
        run_sum2 = run_sum2 + run_sum1;
        diff_mem[p] = '0;
        res.value = {{32{base_mem[p][31]}}, base_mem[p]} + run_sum2;
        res.index = p[9:0];
        res.last = (p + 1 >= len);
        got = 1'b1;
        if (res.last) begin
          rd_ptr = 0;
          run_sum1 = '0;
          run_sum2 = '0;
        end else begin
          rd_ptr = p + 1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int sender_gap();
    int r;
    if (sender_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic request_t random_request(input logic [1:0] req);
    request_t rq;
    rq.req = req;
    rq.index = 10'($urandom);
    rq.value = $urandom;
    rq.rs = 11'($urandom);
    rq.re = 11'($urandom);
    if ($urandom_range(0, 1) == 1) rq.step = $urandom;
    else rq.step = 32'($urandom_range(0, 40)) - 32'd20;
    return rq;
  endfunction

  function automatic row_t row_req(input logic [1:0] req, input logic [9:0] idx,
                                   input logic [31:0] val, input logic [10:0] rs,
                                   input logic [10:0] re, input logic [31:0] st);
    row_t row;
    row = '0;
    row.rq = '{req: req, index: idx, value: val, rs: rs, re: re, step: st};
    return row;
  endfunction

  function automatic row_t row_known(input logic [63:0] v, input logic [9:0] i,
                                     input logic l);
    row_t row;
    row = row_req(rpae_pkg::REQ_READ, 10'd0, 32'd0, 11'd0, 11'd0, 32'd0);
    row.known = 1'b1;
    row.want = '{value: v, index: i, last: l};
    return row;
  endfunction

  function automatic row_t row_length(input logic [10:0] v);
    row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.length = v;
    return row;
  endfunction

  task automatic send_request(input request_t rq, input int gap, input bit known,
                              input element_t want);
    element_t res;
    bit got;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= rq.req;
    in_ch.load_index <= rq.index;
    in_ch.load_value <= rq.value;
    in_ch.range_start <= rq.rs;
    in_ch.range_end <= rq.re;
    in_ch.step <= rq.step;
    do @(posedge clk); while (!in_ch.ready);
    advance_engine(rq, res, got);
    if (got) pending_elements = {pending_elements, known ? want : res};
    if (rq.req == rpae_pkg::REQ_LOAD) written[rq.index] = 1'b1;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_length(input logic [10:0] v);
    in_ch.valid <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.array_length <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_len = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic issue(input request_t rq);
    int unsigned len;
    len = active_length();
    if (rq.req == rpae_pkg::REQ_LOAD || rq.req == rpae_pkg::REQ_READ ||
        (rq.req == rpae_pkg::REQ_UPDATE && rq.rs != 0 && rq.rs <= rq.re &&
         rq.re <= len))
      counted++;
    send_request(rq, sender_gap(), 1'b0, '0);
  endtask

  task automatic issue_read();
    request_t rq;
    if (!written[rd_ptr]) begin
      rq = random_request(rpae_pkg::REQ_LOAD);
      rq.index = rd_ptr[9:0];
      issue(rq);
    end
    issue(random_request(rpae_pkg::REQ_READ));
  endtask

  task automatic issue_job_item();
    request_t rq;
    int r;
    int unsigned e;
    r = $urandom_range(0, 99);
    if (r < 78) begin
      rq = random_request(rpae_pkg::REQ_UPDATE);
      e = $urandom_range(1, active_length());
      rq.re = 11'(e);
      rq.rs = 11'($urandom_range(1, e));
    end else if (r < 88) begin
      rq = random_request(rpae_pkg::REQ_LOAD);
    end else if (r < 96) begin
      rq = random_request(rpae_pkg::REQ_UPDATE);
    end else begin
      rq = random_request(REQ_UNUSED);
    end
    issue(rq);
  endtask

  // result side: random backpressure plus one long hold-off
  initial begin
    element_t want;
    int gap_left, hold_left, r;
    bit held;
    gap_left = 0;
    hold_left = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_elements.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected element: idx %0d value %h last %0b",
                     out_ch.element_index, out_ch.element_value, out_ch.last);
        end else begin
          want = pending_elements.pop_front();
          if (out_ch.element_value !== want.value || out_ch.element_index !== want.index ||
              out_ch.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("mismatch: exp idx %0d val %h last %0b, got idx %0d val %h last %0b",
                       want.index, want.value, want.last,
                       out_ch.element_index, out_ch.element_value, out_ch.last);
          end
        end
      end
      if (!held && results_seen >= STALL_AFTER) begin
        held = 1'b1;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!sink_steady) begin
          r = $urandom_range(0, 99);
          if (r < 15) gap_left = $urandom_range(1, 3);
          else if (r < 18) gap_left = $urandom_range(10, 60);
        end
      end
    end
  end

  initial begin
    row_t rows [ROWS];
    logic [10:0] phase_lengths [7];
    logic [10:0] new_len;
    int unsigned len, n;
    int i, ph;

    for (i = 0; i < DEPTH; i++) begin
      base_mem[i] = '0;
      diff_mem[i] = '0;
      written[i] = 1'b0;
    end
    rd_ptr = 0;
    run_sum1 = '0;
    run_sum2 = '0;
    cfg_len = 11'(rpae_pkg::LEN_RESET);

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_UNUSED;
    in_ch.load_index <= '0;
    in_ch.load_value <= '0;
    in_ch.range_start <= '0;
    in_ch.range_end <= '0;
    in_ch.step <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.array_length <= 11'(rpae_pkg::LEN_RESET);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    rows = '{
      row_req(rpae_pkg::REQ_LOAD, 10'd0, 32'h7FFF_FFFF, 11'd0, 11'd0, 32'd0),
      row_req(rpae_pkg::REQ_LOAD, 10'd1023, 32'h8000_0000, 11'd0, 11'd0, 32'd0),
      row_req(rpae_pkg::REQ_LOAD, 10'd1, 32'hFFFF_FFFF, 11'd0, 11'd0, 32'd0),
      row_req(rpae_pkg::REQ_LOAD, 10'd2, 32'd5, 11'd0, 11'd0, 32'd0),
      row_known(64'h0000_0000_7FFF_FFFF, 10'd0, 1'b0),
      row_known(64'hFFFF_FFFF_FFFF_FFFF, 10'd1, 1'b0),
      // shrink so the pointer lies past the end in mid pass
      row_length(11'd2),
      row_known(64'd5, 10'd2, 1'b1),
      row_length(11'd0),
      row_req(rpae_pkg::REQ_UPDATE, 10'd0, 32'd0, 11'd1, 11'd1, 32'd3),
      row_req(rpae_pkg::REQ_UPDATE, 10'd0, 32'd0, 11'd0, 11'd1, 32'd9),
      row_req(rpae_pkg::REQ_UPDATE, 10'd0, 32'd0, 11'd2, 11'd2, 32'd9),
      row_req(rpae_pkg::REQ_READ, 10'd0, 32'd0, 11'd0, 11'd0, 32'd0),
      row_req(REQ_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 11'h7FF, 11'h7FF, 32'hFFFF_FFFF),
      row_length(11'd2047),
      row_req(rpae_pkg::REQ_UPDATE, 10'd0, 32'd0, 11'd1, 11'd1024, 32'h7FFF_FFFF),
      row_req(rpae_pkg::REQ_UPDATE, 10'd0, 32'd0, 11'd1024, 11'd1024, 32'h8000_0000),
      row_req(rpae_pkg::REQ_UPDATE, 10'd0, 32'd0, 11'd3, 11'd2, 32'd1),
      row_req(rpae_pkg::REQ_UPDATE, 10'd0, 32'd0, 11'd1, 11'd2047, 32'd1),
      row_req(rpae_pkg::REQ_UPDATE, 10'd0, 32'd0, 11'd2047, 11'd2047, 32'd1),
      row_req(rpae_pkg::REQ_UPDATE, 10'd0, 32'd0, 11'd2, 11'd5, 32'hFFFF_FFF9),
      row_req(rpae_pkg::REQ_READ, 10'd0, 32'd0, 11'd0, 11'd0, 32'd0),
      row_req(rpae_pkg::REQ_READ, 10'd0, 32'd0, 11'd0, 11'd0, 32'd0),
      row_req(rpae_pkg::REQ_READ, 10'd0, 32'd0, 11'd0, 11'd0, 32'd0)
    };

    for (i = 0; i < ROWS; i++) begin
      if (rows[i].is_cfg) write_length(rows[i].length);
      else send_request(rows[i].rq, sender_gap(), rows[i].known, rows[i].want);
    end

    phase_lengths = '{11'd1, 11'd2, 11'd1024, 11'd0, 11'd5, 11'd2047, 11'd33};
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 7) new_len = phase_lengths[ph];
      else if ($urandom_range(0, 99) < 80) new_len = 11'($urandom_range(1, 48));
      else new_len = 11'($urandom_range(0, 2047));
      write_length(new_len);
      sender_steady = (ph % 4 == 3);
      sink_steady = (ph % 5 == 2);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        repeat ($urandom_range(0, 5)) issue_job_item();
        len = active_length();
        if (len > 64) n = $urandom_range(1, 40);
        else if (rd_ptr >= len) n = 1;
        else n = len - rd_ptr;
        repeat (n) begin
          // job items, mostly updates, landing in the middle of a pass
          if ($urandom_range(0, 99) < 8) issue_job_item();
          issue_read();
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
